FILE: src/xffp_pkg.sv
package xffp_pkg;

   // Buffer size used for the fixed-size view of the field characters.
   localparam int FIELD_BUF_CHARS = 13;
   localparam int BUF_VIEW = 16;
   localparam int FRAME_LEN_W = 10;
   localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LEN_RESET = 10'd256;

   // Control characters.
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_ETX = 8'h03;
   localparam logic [7:0] CH_US = 8'h1F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_A = 8'h41;
   localparam logic [31:0] TAN_ZEROS = 32'h3030_3030;

   // Result event codes.
   localparam logic [2:0] EV_FIELD = 3'd0;
   localparam logic [2:0] EV_ACK = 3'd1;
   localparam logic [2:0] EV_NAK = 3'd2;
   localparam logic [2:0] EV_ALARM = 3'd3;
   localparam logic [2:0] EV_STATUS = 3'd4;

   // Field kinds.
   localparam logic [2:0] K_TIME = 3'd0;
   localparam logic [2:0] K_DATE = 3'd1;
   localparam logic [2:0] K_TAN = 3'd2;
   localparam logic [2:0] K_TERM = 3'd3;
   localparam logic [2:0] K_BANK = 3'd4;
   localparam logic [2:0] K_ACCT = 3'd5;

   // Alarm codes.
   localparam logic [1:0] AL_DIAG = 2'd1;
   localparam logic [1:0] AL_START = 2'd2;
   localparam logic [1:0] AL_NEW_TAN = 2'd3;

   typedef logic [BUF_VIEW-1:0][7:0] buf_view_type;

   // One result word.
   typedef struct packed {
      logic [2:0] event_res;
      logic [2:0] field_kind;
      logic [3:0] field_len;
      logic [63:0] text_low;
      logic [15:0] text_high;
      logic [1:0] alarm_code;
   } res_type;

   // All results caused by one input byte.
   typedef struct packed {
      logic [1:0] count;
      res_type res0;
      res_type res1;
   } pair_type;

   // Non-field result word.
   function automatic res_type mk_event(input logic [2:0] ev, input logic [1:0] code);
      res_type r;
      r = '0;
      r.event_res = ev;
      r.alarm_code = code;
      return r;
   endfunction

   // Field result with characters reversed; start and len are constants at each call.
   function automatic res_type mk_field(input buf_view_type bv, input logic [2:0] kind,
                                        input int start, input int len);
      res_type r;
      logic [79:0] txt;
      txt = '0;
      for (int i = 0; i < 10; i++) begin
         if (i < len) begin
            txt[8*i +: 8] = bv[start + len - 1 - i];
         end
      end
      r = '0;
      r.event_res = EV_FIELD;
      r.field_kind = kind;
      r.field_len = 4'(len);
      r.text_low = txt[63:0];
      r.text_high = txt[79:64];
      return r;
   endfunction

   // Transaction number in buffer order, first character in the low byte.
   function automatic logic [31:0] tan_value(input buf_view_type bv, input int start,
                                             input int len);
      logic [31:0] v;
      v = '0;
      for (int k = 0; k < 4; k++) begin
         if (k < len) begin
            v[8*k +: 8] = bv[start + k];
         end
      end
      return v;
   endfunction

endpackage

FILE: src/xffp_front.sv
module xffp_front
   import xffp_pkg::*;
#(
   parameter int FieldBufChars = FIELD_BUF_CHARS
) (
   input logic clock,
   input logic reset,
   input logic in_accept,
   input logic [7:0] rx_byte,
   input logic csr_write,
   input logic [FRAME_LEN_W-1:0] csr_data,
   output pair_type pair,
   output logic pair_push
);

   localparam int IdxW = $clog2(FieldBufChars);

   typedef enum logic [8:0] {
      ST_STX = 9'b000000001,
      ST_F1 = 9'b000000010,
      ST_F2 = 9'b000000100,
      ST_F3 = 9'b000001000,
      ST_F4 = 9'b000010000,
      ST_F5 = 9'b000100000,
      ST_F6 = 9'b001000000,
      ST_ETX = 9'b010000000,
      ST_CRC = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      MK_DIAG = 2'd0,
      MK_START = 2'd1,
      MK_STATUS = 2'd2
   } msg_type;

   state_type state_ff, state_in;
   msg_type mk_ff, mk_in;
   logic [FRAME_LEN_W-1:0] max_len_ff;
   logic [7:0] chars_ff [FieldBufChars];
   logic [3:0] fcnt_ff, fcnt_in;
   logic [FRAME_LEN_W:0] frame_ff, frame_in;
   logic [7:0] xor_ff, xor_in;
   logic sw_ff, sw_in, ts_ff, ts_in;
   logic [31:0] ctan_ff, ctan_in, ptan_ff, ptan_in;
   logic [2:0] ctlen_ff, ctlen_in;
   logic [3:0] ptlen_ff, ptlen_in;
   logic wr_en;
   logic [IdxW-1:0] wr_idx;
   logic [7:0] wr_char;
   buf_view_type bv;
   logic [31:0] mask;
   logic tan_new;

   // Fixed-size view of the character buffer.
   always_comb begin
      bv = '0;
      for (int i = 0; i < FieldBufChars; i++) begin
         bv[i] = chars_ff[i];
      end
   end

   // Byte mask for the stored transaction number length.
   always_comb begin
      unique case (ctlen_ff)
         3'd0: mask = 32'h0000_0000;
         3'd1: mask = 32'h0000_00FF;
         3'd2: mask = 32'h0000_FFFF;
         3'd3: mask = 32'h00FF_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
   end

   assign wr_char = (rx_byte == 8'h00) ? CH_SPACE : rx_byte;

   // Parser: one byte per cycle while in_accept is high, up to two results.
   always_comb begin
      logic etx;
      state_in = state_ff;
      mk_in = mk_ff;
      fcnt_in = fcnt_ff;
      frame_in = frame_ff;
      xor_in = xor_ff;
      sw_in = sw_ff;
      ts_in = ts_ff;
      ctan_in = ctan_ff;
      ctlen_in = ctlen_ff;
      ptan_in = ptan_ff;
      ptlen_in = ptlen_ff;
      pair = '0;
      wr_en = 1'b0;
      wr_idx = '0;
      tan_new = 1'b0;
      etx = (rx_byte == CH_ETX);
      if (in_accept) begin
         // Overflowed frame is dropped before this byte.
         if (frame_in > {1'b0, max_len_ff}) begin
            fcnt_in = '0; frame_in = '0; xor_in = '0; sw_in = 1'b0; ts_in = 1'b0;
            state_in = ST_STX;
         end
         if (rx_byte == CH_STX) begin
            fcnt_in = '0; frame_in = '0; xor_in = '0; sw_in = 1'b0; ts_in = 1'b0;
            mk_in = MK_START;
            state_in = ST_F1;
         end else if (rx_byte == CH_US || etx) begin
            if (frame_in[FRAME_LEN_W] == 1'b0) begin
               frame_in = frame_in + 1'b1;
            end
            xor_in = xor_in ^ rx_byte;
            unique case (state_in)
               ST_F1: begin
                  if (fcnt_in == 4'd1 && bv[0] == CH_A) begin
                     sw_in = 1'b1; mk_in = MK_STATUS; state_in = ST_ETX;
                  end else if (fcnt_in == 4'd4) begin
                     pair.res0 = mk_field(bv, K_TIME, 0, 4); pair.count = 2'd1;
                     mk_in = MK_START; state_in = ST_F2;
                  end else if (fcnt_in == 4'd10) begin
                     pair.res0 = mk_field(bv, K_TIME, 0, 4);
                     pair.res1 = mk_field(bv, K_DATE, 4, 6); pair.count = 2'd2;
                     mk_in = MK_START; state_in = ST_F3;
                  end else if (fcnt_in == 4'd11) begin
                     pair.res0 = mk_field(bv, K_TIME, 0, 4);
                     pair.res1 = mk_field(bv, K_DATE, 5, 6); pair.count = 2'd2;
                     mk_in = MK_START; state_in = ST_F3;
                  end else begin
                     mk_in = MK_START; state_in = ST_ETX;
                  end
                  fcnt_in = '0;
               end
               ST_F2: begin
                  if (fcnt_in == 4'd6) begin
                     pair.res0 = mk_field(bv, K_DATE, 0, 6); pair.count = 2'd1;
                     state_in = ST_F3;
                  end else if (fcnt_in == 4'd9) begin
                     pair.res0 = mk_field(bv, K_DATE, 0, 6);
                     pair.res1 = mk_field(bv, K_TAN, 6, 3); pair.count = 2'd2;
                     ctan_in = tan_value(bv, 6, 3); ctlen_in = 3'd3; ts_in = 1'b1;
                     state_in = ST_F4;
                  end else if (fcnt_in == 4'd10) begin
                     pair.res0 = mk_field(bv, K_DATE, 0, 6);
                     pair.res1 = mk_field(bv, K_TAN, 7, 3); pair.count = 2'd2;
                     ctan_in = tan_value(bv, 7, 3); ctlen_in = 3'd3; ts_in = 1'b1;
                     state_in = ST_F4;
                  end else if (fcnt_in == 4'd11) begin
                     pair.res0 = mk_field(bv, K_DATE, 0, 6);
                     pair.res1 = mk_field(bv, K_TAN, 7, 4); pair.count = 2'd2;
                     ctan_in = tan_value(bv, 7, 4); ctlen_in = 3'd4; ts_in = 1'b1;
                     mk_in = MK_DIAG; state_in = ST_F4;
                  end else begin
                     state_in = ST_ETX;
                  end
                  fcnt_in = '0;
               end
               ST_F3: begin
                  if (fcnt_in == 4'd3) begin
                     pair.res0 = mk_field(bv, K_TAN, 0, 3); pair.count = 2'd1;
                     ctan_in = tan_value(bv, 0, 3); ctlen_in = 3'd3; ts_in = 1'b1;
                     mk_in = MK_START; state_in = ST_F4;
                  end else if (fcnt_in == 4'd4) begin
                     pair.res0 = mk_field(bv, K_TAN, 0, 4); pair.count = 2'd1;
                     ctan_in = tan_value(bv, 0, 4); ctlen_in = 3'd4; ts_in = 1'b1;
                     mk_in = MK_DIAG; state_in = ST_F4;
                  end else if (fcnt_in == 4'd10 || fcnt_in == 4'd11) begin
                     pair.res0 = mk_field(bv, K_TAN, 0, 4);
                     pair.res1 = (fcnt_in == 4'd10) ? mk_field(bv, K_TERM, 4, 6)
                                                    : mk_field(bv, K_TERM, 5, 6);
                     pair.count = 2'd2;
                     ctan_in = tan_value(bv, 0, 4); ctlen_in = 3'd4; ts_in = 1'b1;
                     mk_in = MK_DIAG; state_in = ST_ETX;
                  end else if (fcnt_in == 4'd12 || fcnt_in == 4'd13) begin
                     pair.res0 = mk_field(bv, K_TAN, 0, 3);
                     pair.res1 = (fcnt_in == 4'd12) ? mk_field(bv, K_BANK, 4, 8)
                                                    : mk_field(bv, K_BANK, 5, 8);
                     pair.count = 2'd2;
                     ctan_in = tan_value(bv, 0, 3); ctlen_in = 3'd3; ts_in = 1'b1;
                     mk_in = MK_START; state_in = ST_F6;
                  end else begin
                     mk_in = MK_START; state_in = ST_ETX;
                  end
                  fcnt_in = '0;
               end
               ST_F4: begin
                  if (fcnt_in == 4'd0) begin
                     mk_in = MK_START; state_in = ST_F5;
                  end else if (fcnt_in == 4'd6 && etx) begin
                     pair.res0 = mk_field(bv, K_TERM, 0, 6); pair.count = 2'd1;
                     mk_in = MK_DIAG; state_in = ST_CRC;
                  end else if (fcnt_in == 4'd8) begin
                     pair.res0 = mk_field(bv, K_BANK, 0, 8); pair.count = 2'd1;
                     mk_in = MK_START; state_in = ST_F6;
                  end else begin
                     mk_in = MK_START; state_in = ST_ETX;
                  end
                  fcnt_in = '0;
               end
               ST_F5: begin
                  if (fcnt_in == 4'd8) begin
                     pair.res0 = mk_field(bv, K_BANK, 0, 8); pair.count = 2'd1;
                     state_in = ST_F6;
                  end else begin
                     state_in = ST_ETX;
                  end
                  mk_in = MK_START;
                  fcnt_in = '0;
               end
               ST_F6: begin
                  if (etx && fcnt_in == 4'd10) begin
                     pair.res0 = mk_field(bv, K_ACCT, 0, 10); pair.count = 2'd1;
                     mk_in = MK_START; state_in = ST_CRC;
                  end
               end
               ST_ETX: begin
                  if (etx) begin
                     state_in = ST_CRC;
                  end
               end
               default: begin
               end
            endcase
         end else if (state_in != ST_CRC) begin
            // Ordinary character: count, checksum and buffer it.
            if (frame_in[FRAME_LEN_W] == 1'b0) begin
               frame_in = frame_in + 1'b1;
            end
            xor_in = xor_in ^ rx_byte;
            wr_en = ({1'b0, fcnt_in} < 5'(FieldBufChars));
            wr_idx = fcnt_in[IdxW-1:0];
            if (fcnt_in != 4'd15) begin
               fcnt_in = fcnt_in + 1'b1;
            end
         end else begin
            // Checksum byte: answer, then alarm or status request.
            pair.res0 = mk_event((xor_in == rx_byte) ? EV_ACK : EV_NAK, 2'd0);
            pair.count = 2'd1;
            if (mk_in == MK_DIAG) begin
               pair.res1 = mk_event(EV_ALARM, AL_DIAG); pair.count = 2'd2;
            end else if (mk_in == MK_START) begin
               tan_new = ts_in && (ctan_ff != (TAN_ZEROS & mask)) &&
                         !((ptlen_ff >= {1'b0, ctlen_ff}) && ((ptan_ff & mask) == ctan_ff));
               pair.res1 = mk_event(EV_ALARM, tan_new ? AL_NEW_TAN : AL_START);
               pair.count = 2'd2;
               if (tan_new) begin
                  ptan_in = ctan_ff; ptlen_in = {1'b0, ctlen_ff};
               end
            end else if (sw_in) begin
               pair.res1 = mk_event(EV_STATUS, 2'd0); pair.count = 2'd2;
            end
            fcnt_in = '0; frame_in = '0; xor_in = '0; sw_in = 1'b0; ts_in = 1'b0;
            state_in = ST_STX;
         end
      end
   end

   assign pair_push = in_accept && (pair.count != 2'd0);

   // Control and frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_STX;
         mk_ff <= MK_DIAG;
         max_len_ff <= MAX_FRAME_LEN_RESET;
         fcnt_ff <= '0;
         frame_ff <= '0;
         xor_ff <= '0;
         sw_ff <= 1'b0;
         ts_ff <= 1'b0;
         ctan_ff <= '0;
         ctlen_ff <= '0;
         ptan_ff <= TAN_ZEROS;
         ptlen_ff <= 4'd10;
      end else begin
         state_ff <= state_in;
         mk_ff <= mk_in;
         if (csr_write) begin
            max_len_ff <= csr_data;
         end
         fcnt_ff <= fcnt_in;
         frame_ff <= frame_in;
         xor_ff <= xor_in;
         sw_ff <= sw_in;
         ts_ff <= ts_in;
         ctan_ff <= ctan_in;
         ctlen_ff <= ctlen_in;
         ptan_ff <= ptan_in;
         ptlen_ff <= ptlen_in;
      end
   end

   // Character buffer, written at the current field position.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         chars_ff[wr_idx] <= wr_char;
      end
   end

endmodule

FILE: src/xffp_queue.sv
module xffp_queue
   import xffp_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic push,
   input pair_type push_data,
   input logic pop,
   output pair_type head,
   output logic not_empty,
   output logic full
);

   pair_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign head = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);
   assign full = (count_ff == 2'd2);

   // Two-entry queue of per-byte result groups.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/xffp_back.sv
module xffp_back
   import xffp_pkg::*;
(
   input logic clock,
   input logic reset,
   input pair_type head,
   input logic head_valid,
   output logic pop,
   output logic rsp_valid,
   input logic rsp_stall,
   output res_type rsp_res,
   output logic rsp_last
);

   logic sel_ff;
   logic take;

   assign rsp_valid = head_valid;
   assign rsp_res = sel_ff ? head.res1 : head.res0;
   assign rsp_last = sel_ff || (head.count == 2'd1);
   assign take = head_valid && !rsp_stall;
   assign pop = take && rsp_last;

   // Walks through the one or two words of the head group.
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else if (take) begin
         sel_ff <= !rsp_last;
      end
   end

endmodule

FILE: src/xor_framed_field_parser.sv
// Results: each result word is registered in the two-entry result queue before output.
// Throughput: one byte per cycle; a byte that causes two words presents them on the output
// one after the other, and the two-entry result queue stalls input when full.
// Reset: synchronous, active high; parser waits for STX, frame length limit is 256,
// and the field character buffer holds no defined contents until written.
module xor_framed_field_parser
   import xffp_pkg::*;
#(
   parameter int FieldBufChars = FIELD_BUF_CHARS
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_rx_byte,
   input logic req_chunk_last,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [2:0] rsp_field_kind,
   output logic [3:0] rsp_field_len,
   output logic [63:0] rsp_text_low,
   output logic [15:0] rsp_text_high,
   output logic [1:0] rsp_alarm_code,
   output logic rsp_last,
   input logic csr_valid,
   output logic csr_ready,
   input logic [FRAME_LEN_W-1:0] csr_data
);

   pair_type pair, head;
   logic pair_push, pop, not_empty, full, in_accept;
   res_type res;

   assign req_stall = full;
   assign in_accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   xffp_front #(.FieldBufChars(FieldBufChars)) u_front (
      .clock(clock),
      .reset(reset),
      .in_accept(in_accept),
      .rx_byte(req_rx_byte),
      .csr_write(csr_valid && csr_ready),
      .csr_data(csr_data),
      .pair(pair),
      .pair_push(pair_push)
   );

   xffp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(pair_push),
      .push_data(pair),
      .pop(pop),
      .head(head),
      .not_empty(not_empty),
      .full(full)
   );

   xffp_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .head_valid(not_empty),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_res(res),
      .rsp_last(rsp_last)
   );

   assign rsp_event_res = res.event_res;
   assign rsp_field_kind = res.field_kind;
   assign rsp_field_len = res.field_len;
   assign rsp_text_low = res.text_low;
   assign rsp_text_high = res.text_high;
   assign rsp_alarm_code = res.alarm_code;

endmodule

FILE: verif/xor_framed_field_parser_tb.sv
`timescale 1ns / 1ps

module xor_framed_field_parser_tb;
   import xffp_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int QUIET_TAIL = 150;

   // Parser states of the local predictor.
   typedef enum logic [3:0] {
      P_WAIT_STX, P_TIME, P_DATE, P_TAN, P_TERM, P_BANK, P_ACCT, P_WAIT_ETX, P_CHECKSUM
   } parse_state_e;

   // Kind of message that decides the alarm code.
   typedef enum logic [1:0] {MSG_DIAG, MSG_START, MSG_STATUS} msg_kind_e;

   typedef struct {
      logic [2:0] ev;
      logic [2:0] kind;
      logic [3:0] len;
      logic [63:0] lo;
      logic [15:0] hi;
      logic [1:0] code;
      logic last;
   } word_t;

   // One directed row: a byte (or the running checksum) and, where obvious, its words.
   typedef struct {
      logic [7:0] b;
      bit use_sum;
      bit typed;
      int n;
      logic [2:0] ev0;
      logic [1:0] code0;
      logic [2:0] ev1;
      logic [1:0] code1;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_rx_byte = '0;
   logic req_chunk_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_event_res;
   logic [2:0] rsp_field_kind;
   logic [3:0] rsp_field_len;
   logic [63:0] rsp_text_low;
   logic [15:0] rsp_text_high;
   logic [1:0] rsp_alarm_code;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [FRAME_LEN_W-1:0] csr_data = '0;

   xor_framed_field_parser dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_chunk_last(req_chunk_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_res(rsp_event_res),
      .rsp_field_kind(rsp_field_kind),
      .rsp_field_len(rsp_field_len),
      .rsp_text_low(rsp_text_low),
      .rsp_text_high(rsp_text_high),
      .rsp_alarm_code(rsp_alarm_code),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state.
   parse_state_e pst;
   msg_kind_e mkind;
   logic [7:0] fbuf [FIELD_BUF_CHARS];
   int fcnt;
   int frame_bytes;
   logic [7:0] xsum;
   bit status_wanted;
   bit tan_seen;
   logic [31:0] cur_tan;
   int cur_tan_len;
   logic [31:0] prev_tan;
   int prev_tan_len;
   int frame_limit;

   word_t expected_words[$];
   word_t byte_words[$];

   int mismatches = 0;
   int accepted = 0;
   int total_bytes = 950;
   int cycles = 0;
   int idle_pct = 12;
   bit quiet = 1'b0;
   bit failed = 1'b0;

   function automatic void clear_frame();
      fcnt = 0;
      frame_bytes = 0;
      xsum = '0;
      status_wanted = 1'b0;
      tan_seen = 1'b0;
   endfunction

   function automatic void add_word(logic [2:0] ev, logic [1:0] code);
      word_t w;
      w = '{ev: ev, kind: '0, len: '0, lo: '0, hi: '0, code: code, last: 1'b0};
      if (byte_words.size() < 2) byte_words.push_back(w);
   endfunction

   // A field is reported with its characters in reverse order.
   function automatic void add_field(logic [2:0] kind, int start, int len);
      word_t w;
      logic [79:0] txt;
      int idx;
      txt = '0;
      for (int i = 0; i < len && i < 10; i++) begin
         idx = start + len - 1 - i;
         txt[8*i +: 8] = (idx < FIELD_BUF_CHARS) ? fbuf[idx] : 8'h00;
      end
      w = '{ev: EV_FIELD, kind: kind, len: 4'(len), lo: txt[63:0], hi: txt[79:64],
            code: '0, last: 1'b0};
      if (byte_words.size() < 2) byte_words.push_back(w);
   endfunction

   function automatic void add_tan(int start, int len);
      logic [31:0] v;
      v = '0;
      add_field(K_TAN, start, len);
      for (int k = 0; k < len && k < 4; k++) begin
         v[8*k +: 8] = (start + k < FIELD_BUF_CHARS) ? fbuf[start + k] : 8'h00;
      end
      cur_tan = v;
      cur_tan_len = len;
      tan_seen = 1'b1;
   endfunction

   // A transaction number is new unless absent, all zeros, or equal to the last one.
   function automatic bit tan_fresh();
      logic [31:0] mask;
      if (!tan_seen) return 1'b0;
      mask = 32'((64'd1 << (8 * cur_tan_len)) - 64'd1);
      if (cur_tan == (TAN_ZEROS & mask)) return 1'b0;
      if (prev_tan_len >= cur_tan_len && (prev_tan & mask) == cur_tan) return 1'b0;
      prev_tan = cur_tan;
      prev_tan_len = cur_tan_len;
      return 1'b1;
   endfunction

   // Field boundary: fields are told apart by their lengths.
   function automatic void on_boundary(logic [7:0] b);
      int c;
      bit etx;
      c = fcnt;
      etx = (b == CH_ETX);
      case (pst)
         P_TIME: begin
            if (c == 1 && fbuf[0] == CH_A) begin
               status_wanted = 1'b1;
               mkind = MSG_STATUS;
               pst = P_WAIT_ETX;
            end else if (c == 4) begin
               add_field(K_TIME, 0, 4);
               mkind = MSG_START;
               pst = P_DATE;
            end else if (c == 10 || c == 11) begin
               // Time and date run together; an eleventh character is skipped.
               add_field(K_TIME, 0, 4);
               add_field(K_DATE, c - 6, 6);
               mkind = MSG_START;
               pst = P_TAN;
            end else begin
               mkind = MSG_START;
               pst = P_WAIT_ETX;
            end
            fcnt = 0;
         end
         P_DATE: begin
            if (c == 6) begin
               add_field(K_DATE, 0, 6);
               pst = P_TAN;
            end else if (c == 9 || c == 10) begin
               add_field(K_DATE, 0, 6);
               add_tan(c - 3, 3);
               pst = P_TERM;
            end else if (c == 11) begin
               add_field(K_DATE, 0, 6);
               add_tan(7, 4);
               mkind = MSG_DIAG;
               pst = P_TERM;
            end else begin
               pst = P_WAIT_ETX;
            end
            fcnt = 0;
         end
         P_TAN: begin
            if (c == 3) begin
               add_tan(0, 3);
               mkind = MSG_START;
               pst = P_TERM;
            end else if (c == 4) begin
               add_tan(0, 4);
               mkind = MSG_DIAG;
               pst = P_TERM;
            end else if (c == 10 || c == 11) begin
               add_tan(0, 4);
               add_field(K_TERM, c - 6, 6);
               mkind = MSG_DIAG;
               pst = P_WAIT_ETX;
            end else if (c == 12 || c == 13) begin
               add_tan(0, 3);
               add_field(K_BANK, c - 8, 8);
               mkind = MSG_START;
               pst = P_ACCT;
            end else begin
               mkind = MSG_START;
               pst = P_WAIT_ETX;
            end
            fcnt = 0;
         end
         P_TERM: begin
            if (c == 0) begin
               mkind = MSG_START;
               pst = P_BANK;
            end else if (c == 6 && etx) begin
               add_field(K_TERM, 0, 6);
               mkind = MSG_DIAG;
               pst = P_CHECKSUM;
            end else if (c == 8) begin
               add_field(K_BANK, 0, 8);
               mkind = MSG_START;
               pst = P_ACCT;
            end else begin
               mkind = MSG_START;
               pst = P_WAIT_ETX;
            end
            fcnt = 0;
         end
         P_BANK: begin
            if (c == 8) begin
               add_field(K_BANK, 0, 8);
               pst = P_ACCT;
            end else begin
               pst = P_WAIT_ETX;
            end
            mkind = MSG_START;
            fcnt = 0;
         end
         P_ACCT: begin
            // A wrong account keeps buffering without clearing the count.
            if (etx && c == 10) begin
               add_field(K_ACCT, 0, 10);
               mkind = MSG_START;
               pst = P_CHECKSUM;
            end
         end
         P_WAIT_ETX: begin
            if (etx) pst = P_CHECKSUM;
         end
         default: ;
      endcase
   endfunction

   // Works out the words that one accepted byte causes.
   function automatic void predict_byte(logic [7:0] b);
      byte_words.delete();
      if (frame_bytes > frame_limit) begin
         clear_frame();
         pst = P_WAIT_STX;
      end
      if (b == CH_STX) begin
         clear_frame();
         mkind = MSG_START;
         pst = P_TIME;
      end else if (b == CH_US || b == CH_ETX) begin
         if (frame_bytes < 1024) frame_bytes++;
         xsum ^= b;
         on_boundary(b);
      end else if (pst != P_CHECKSUM) begin
         if (frame_bytes < 1024) frame_bytes++;
         xsum ^= b;
         // NUL is kept as a space.
         if (fcnt < FIELD_BUF_CHARS) fbuf[fcnt] = (b == 8'h00) ? CH_SPACE : b;
         if (fcnt < 15) fcnt++;
      end else begin
         add_word((xsum == b) ? EV_ACK : EV_NAK, 2'd0);
         if (mkind == MSG_DIAG) add_word(EV_ALARM, AL_DIAG);
         else if (mkind == MSG_START) add_word(EV_ALARM, tan_fresh() ? AL_NEW_TAN : AL_START);
         else if (status_wanted) add_word(EV_STATUS, 2'd0);
         clear_frame();
         pst = P_WAIT_STX;
      end
      if (byte_words.size() > 0) byte_words[byte_words.size() - 1].last = 1'b1;
   endfunction

   function automatic void queue_byte_words();
      foreach (byte_words[i]) expected_words.push_back(byte_words[i]);
   endfunction

   // Offers one byte, with an occasional gap first, and predicts it on acceptance.
   task automatic send_byte(logic [7:0] b);
      if (!quiet && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_chunk_last <= 1'($urandom_range(0, 1));
      do @(posedge clock); while (req_stall);
      accepted++;
      predict_byte(b);
      queue_byte_words();
   endtask

   // Writes the frame limit once everything in flight has drained.
   task automatic write_limit(logic [FRAME_LEN_W-1:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      frame_limit = int'(v);
   endtask

   function automatic logic [7:0] field_char();
      logic [7:0] c;
      if ($urandom_range(0, 99) < 80) return 8'($urandom_range(8'h30, 8'h32));
      do c = 8'($urandom_range(0, 255)); while (c == CH_STX || c == CH_ETX || c == CH_US);
      return c;
   endfunction

   // Builds one frame from a segment pattern, with occasional damage, and sends it.
   task automatic send_frame();
      int segs[$];
      logic [7:0] fb[$];
      logic [7:0] sum;
      int pick;
      pick = $urandom_range(0, 12);
      case (pick)
         0: segs = '{1};
         1: segs = '{4, 6, 3, 0, 8, 10};
         2: segs = '{4, 6, 4, 6};
         3: segs = '{10, 3, 0, 8, 10};
         4: segs = '{11, 4, 6};
         5: segs = '{4, 9, 0, 8, 10};
         6: segs = '{4, 11, 6};
         7: segs = '{4, 6, 13, 10};
         8: segs = '{4, 6, 10 + $urandom_range(0, 1)};
         9: segs = '{4, 6, 12, 10};
         10: segs = '{4, 10, 8, 10};
         default: begin
            repeat ($urandom_range(1, 5)) segs.push_back($urandom_range(0, 16));
         end
      endcase
      fb.push_back(CH_STX);
      foreach (segs[s]) begin
         for (int i = 0; i < segs[s]; i++) begin
            fb.push_back((pick == 0) ? CH_A : field_char());
         end
         fb.push_back((s == segs.size() - 1) ? CH_ETX : CH_US);
      end
      if ($urandom_range(0, 99) < 6) fb[$urandom_range(1, fb.size() - 1)] = 8'($urandom);
      sum = '0;
      for (int i = 1; i < fb.size(); i++) sum ^= fb[i];
      if ($urandom_range(0, 99) < 8) sum ^= 8'($urandom_range(1, 255));
      fb.push_back(sum);
      foreach (fb[i]) send_byte(fb[i]);
   endtask

   // Result checker against the oldest expected word.
   always @(posedge clock) begin
      word_t w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: event %0d", rsp_event_res);
         end else begin
            w = expected_words.pop_front();
            if (rsp_event_res !== w.ev || rsp_field_kind !== w.kind
                || rsp_field_len !== w.len || rsp_text_low !== w.lo
                || rsp_text_high !== w.hi || rsp_alarm_code !== w.code
                || rsp_last !== w.last) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp ev %0d kind %0d len %0d text %h_%h code %0d last %0d",
                           w.ev, w.kind, w.len, w.hi, w.lo, w.code, w.last);
                  $display("          got ev %0d kind %0d len %0d text %h_%h code %0d last %0d",
                           rsp_event_res, rsp_field_kind, rsp_field_len, rsp_text_high,
                           rsp_text_low, rsp_alarm_code, rsp_last);
               end
            end
         end
      end
   end

   // Receiver back-pressure: random bursts, plus one long hold-off mid-run.
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (!hold_done && accepted >= 300) begin
         hold_done <= 1'b1;
         hold_left <= 200;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 99) < 8) begin
         stall_left <= $urandom_range(1, 18);
      end
      rsp_stall <= (hold_left > 1) || (stall_left > 1)
                   || (!quiet && stall_left == 0 && $urandom_range(0, 99) < 8);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Directed opening: status frames, a short start frame, bytes outside a frame.
   row_t directed [21] = '{
      '{CH_STX, 0, 0, 0, 0, 0, 0, 0},
      '{CH_A, 0, 0, 0, 0, 0, 0, 0},
      '{CH_US, 0, 0, 0, 0, 0, 0, 0},
      '{CH_ETX, 0, 0, 0, 0, 0, 0, 0},
      '{8'h00, 1, 1, 2, EV_ACK, 2'd0, EV_STATUS, 2'd0},
      '{CH_STX, 0, 0, 0, 0, 0, 0, 0},
      '{CH_A, 0, 0, 0, 0, 0, 0, 0},
      '{CH_US, 0, 0, 0, 0, 0, 0, 0},
      '{CH_ETX, 0, 0, 0, 0, 0, 0, 0},
      '{8'h00, 0, 1, 2, EV_NAK, 2'd0, EV_STATUS, 2'd0},
      '{CH_STX, 0, 0, 0, 0, 0, 0, 0},
      '{8'h00, 0, 0, 0, 0, 0, 0, 0},
      '{8'hFF, 0, 0, 0, 0, 0, 0, 0},
      '{8'h33, 0, 0, 0, 0, 0, 0, 0},
      '{8'h34, 0, 0, 0, 0, 0, 0, 0},
      '{CH_US, 0, 0, 0, 0, 0, 0, 0},
      '{CH_ETX, 0, 0, 0, 0, 0, 0, 0},
      '{CH_ETX, 0, 0, 0, 0, 0, 0, 0},
      '{8'h00, 1, 1, 2, EV_ACK, 2'd0, EV_ALARM, AL_START},
      '{CH_A, 0, 0, 0, 0, 0, 0, 0},
      '{CH_US, 0, 0, 0, 0, 0, 0, 0}
   };

   logic [FRAME_LEN_W-1:0] limits [6] = '{10'd256, 10'd1023, 10'd20, 10'd1, 10'd60, 10'd256};

   initial begin
      word_t w;
      logic [7:0] b;
      pst = P_WAIT_STX;
      mkind = MSG_DIAG;
      foreach (fbuf[i]) fbuf[i] = '0;
      clear_frame();
      cur_tan = '0;
      cur_tan_len = 0;
      prev_tan = TAN_ZEROS;
      prev_tan_len = 10;
      frame_limit = int'(MAX_FRAME_LEN_RESET);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows; typed rows replace the predicted words with the obvious ones.
      foreach (directed[r]) begin
         b = directed[r].use_sum ? xsum : directed[r].b;
         if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_rx_byte <= b;
         req_chunk_last <= 1'(r % 2);
         do @(posedge clock); while (req_stall);
         accepted++;
         predict_byte(b);
         if (directed[r].typed) begin
            w = '{ev: directed[r].ev0, kind: '0, len: '0, lo: '0, hi: '0,
                  code: directed[r].code0, last: 1'b0};
            expected_words.push_back(w);
            w.ev = directed[r].ev1;
            w.code = directed[r].code1;
            w.last = 1'b1;
            expected_words.push_back(w);
         end else begin
            queue_byte_words();
         end
      end

      // Random phases at several frame limits; the last phase runs without idling.
      foreach (limits[p]) begin
         if (p > 0) write_limit(limits[p]);
         idle_pct = (p % 3 == 2) ? 0 : 15;
         while (accepted < (p + 1) * total_bytes / 6) begin
            quiet = (accepted > total_bytes - QUIET_TAIL);
            if ($urandom_range(0, 99) < 12) begin
               repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else begin
               send_frame();
            end
         end
      end
      quiet = 1'b1;
      req_valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
